// ----- src/imap_flags_list_parser_macros.svh -----
// ----------------------------------------------------------------------------
// IMAP FLAGS list parser assertion macros
// Shared property wrappers for the parser checker.
// ----------------------------------------------------------------------------
`ifndef IMAP_FLAGS_LIST_PARSER_MACROS_SVH
`define IMAP_FLAGS_LIST_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define IFP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ifp assertion failed");

// next-cycle implication, disabled during reset
`define IFP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ifp assertion failed");

`endif

// ----- src/ifp_pkg.sv -----
// ----------------------------------------------------------------------------
// ifp_pkg
// Types, keyword tables and helpers for the IMAP FLAGS list parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ifp_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_PAREN,
    PH_FIRST,
    PH_GAP,
    PH_KEYWORD,
    PH_UNK_SYS,
    PH_UNK_CUST
  } phase_e;

  typedef enum logic [2:0] {
    KW_DELETED,
    KW_FLAGGED,
    KW_ANSWERED,
    KW_SEEN,
    KW_RECENT,
    KW_OLD,
    KW_BACKSLASH,
    KW_NONE
  } kw_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOT_FLAGS,
    ST_NO_PAREN,
    ST_UNTERM
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  match_pos;
    kw_e         kw_sel;
    logic [4:0]  flag_bits;
    logic [3:0]  sys_cnt;
    logic [3:0]  cust_cnt;
    logic [15:0] byte_cnt;
    logic        done;
  } parse_state_t;

  typedef struct packed {
    status_e     status;
    logic        deleted;
    logic        flagged;
    logic        replied;
    logic        seen_read;
    logic        old_mark;
    logic [3:0]  system_count;
    logic [3:0]  custom_count;
    logic [15:0] consumed;
  } result_t;

  localparam parse_state_t PARSE_IDLE = '{
    phase:     PH_PREFIX,
    match_pos: 4'd0,
    kw_sel:    KW_NONE,
    flag_bits: 5'd0,
    sys_cnt:   4'd0,
    cust_cnt:  4'd0,
    byte_cnt:  16'd0,
    done:      1'b0
  };

  localparam logic [3:0] PREFIX_LEN = 4'd5;
  localparam logic [0:4][7:0] PREFIX_TXT = "flags";

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;

  localparam int unsigned FLAG_OLD = 4;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // keyword text, left aligned, space padded
  function automatic logic [7:0] kw_char(kw_e k, logic [3:0] p);
    logic [0:9][7:0] txt;
    case (k)
      KW_DELETED:  txt = "\\deleted  ";
      KW_FLAGGED:  txt = "\\flagged  ";
      KW_ANSWERED: txt = "\\answered ";
      KW_SEEN:     txt = "\\seen     ";
      KW_RECENT:   txt = "\\recent   ";
      KW_OLD:      txt = "old       ";
      default:     txt = "          ";
    endcase
    return txt[p];
  endfunction

  function automatic logic [3:0] kw_len(kw_e k);
    case (k)
      KW_DELETED:  return 4'd8;
      KW_FLAGGED:  return 4'd8;
      KW_ANSWERED: return 4'd9;
      KW_SEEN:     return 4'd5;
      KW_RECENT:   return 4'd7;
      KW_OLD:      return 4'd3;
      default:     return 4'd0;
    endcase
  endfunction

  function automatic status_e end_status(phase_e ph);
    case (ph)
      PH_PREFIX: return ST_NOT_FLAGS;
      PH_PAREN:  return ST_NO_PAREN;
      default:   return ST_UNTERM;
    endcase
  endfunction

  function automatic logic [3:0] sat_inc4(logic [3:0] v);
    return (v == 4'hF) ? v : v + 4'd1;
  endfunction

endpackage

// ----- src/ifp_step.sv -----
// ----------------------------------------------------------------------------
// ifp_step
// Next-state and result logic for one response byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifp_step (
  input  ifp_pkg::parse_state_t state_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  logic                  mark_old_i,
  output ifp_pkg::parse_state_t state_o,
  output logic                  res_valid_o,
  output ifp_pkg::result_t      res_o
);
  import ifp_pkg::*;

  function automatic parse_state_t start_token(parse_state_t s, logic [7:0] c);
    parse_state_t r;
    r = s;
    if (c == CH_BSLASH) begin
      r.phase     = PH_KEYWORD;
      r.kw_sel    = KW_BACKSLASH;
      r.match_pos = 4'd1;
    end else if (to_lower(c) == "o") begin
      r.phase     = PH_KEYWORD;
      r.kw_sel    = KW_OLD;
      r.match_pos = 4'd1;
    end else begin
      r.phase  = PH_UNK_CUST;
      r.kw_sel = KW_NONE;
    end
    return r;
  endfunction

  function automatic parse_state_t unknown_tok(parse_state_t s, logic tok_end,
                                               logic close_paren);
    parse_state_t r;
    r = s;
    if (tok_end) begin
      if (s.phase == PH_UNK_SYS) begin
        r.sys_cnt = sat_inc4(s.sys_cnt);
      end else begin
        r.cust_cnt = sat_inc4(s.cust_cnt);
      end
      r.kw_sel = KW_NONE;
      if (!close_paren) begin
        r.phase = PH_GAP;
      end
    end
    return r;
  endfunction

  logic [7:0]   lc;
  logic         ws;
  logic         close_paren;
  logic         tok_end;
  logic         hit;
  status_e      st_code;
  parse_state_t nxt;

  assign lc          = to_lower(byte_i);
  assign ws          = is_ws(byte_i);
  assign close_paren = (byte_i == CH_CLOSE);
  assign tok_end     = ws || close_paren;

  always_comb begin
    nxt     = state_i;
    hit     = 1'b0;
    st_code = ST_OK;
    if (state_i.done) begin
      hit = 1'b0;
    end else if (byte_i == 8'h00) begin
      hit     = 1'b1;
      st_code = end_status(state_i.phase);
    end else begin
      if (nxt.byte_cnt != 16'hFFFF) begin
        nxt.byte_cnt = nxt.byte_cnt + 16'd1;
      end
      case (state_i.phase)
        PH_PREFIX: begin
          if (state_i.match_pos >= PREFIX_LEN ||
              lc != PREFIX_TXT[state_i.match_pos[2:0]]) begin
            hit     = 1'b1;
            st_code = ST_NOT_FLAGS;
          end else if (state_i.match_pos == PREFIX_LEN - 4'd1) begin
            nxt.phase     = PH_PAREN;
            nxt.match_pos = 4'd0;
          end else begin
            nxt.match_pos = state_i.match_pos + 4'd1;
          end
        end
        PH_PAREN: begin
          if (ws) begin
            hit = 1'b0;
          end else if (byte_i == CH_OPEN) begin
            nxt.phase = PH_FIRST;
          end else begin
            hit     = 1'b1;
            st_code = ST_NO_PAREN;
          end
        end
        PH_FIRST: begin
          if (ws) begin
            // leading blank counts as an empty custom token
            nxt.cust_cnt = sat_inc4(state_i.cust_cnt);
            nxt.phase    = PH_GAP;
          end else if (close_paren) begin
            hit = 1'b1;
          end else begin
            nxt = start_token(nxt, byte_i);
          end
        end
        PH_KEYWORD: begin
          if (state_i.kw_sel == KW_BACKSLASH) begin
            nxt.match_pos = 4'd2;
            case (lc)
              "d":     nxt.kw_sel = KW_DELETED;
              "f":     nxt.kw_sel = KW_FLAGGED;
              "a":     nxt.kw_sel = KW_ANSWERED;
              "s":     nxt.kw_sel = KW_SEEN;
              "r":     nxt.kw_sel = KW_RECENT;
              default: begin
                nxt.match_pos = state_i.match_pos;
                nxt.phase     = PH_UNK_SYS;
                nxt           = unknown_tok(nxt, tok_end, close_paren);
                hit           = close_paren;
              end
            endcase
          end else if (state_i.kw_sel != KW_NONE &&
                       state_i.match_pos < kw_len(state_i.kw_sel) &&
                       lc == kw_char(state_i.kw_sel, state_i.match_pos)) begin
            if (state_i.match_pos + 4'd1 == kw_len(state_i.kw_sel)) begin
              case (state_i.kw_sel)
                KW_DELETED:  nxt.flag_bits[0] = 1'b1;
                KW_FLAGGED:  nxt.flag_bits[1] = 1'b1;
                KW_ANSWERED: nxt.flag_bits[2] = 1'b1;
                KW_SEEN:     nxt.flag_bits[3] = 1'b1;
                KW_OLD:      nxt.flag_bits[FLAG_OLD] = mark_old_i;
                default:     nxt.flag_bits = state_i.flag_bits;
              endcase
              nxt.phase     = PH_GAP;
              nxt.kw_sel    = KW_NONE;
              nxt.match_pos = 4'd0;
            end else begin
              nxt.match_pos = state_i.match_pos + 4'd1;
            end
          end else begin
            nxt.phase = (state_i.kw_sel == KW_OLD) ? PH_UNK_CUST : PH_UNK_SYS;
            nxt       = unknown_tok(nxt, tok_end, close_paren);
            hit       = close_paren;
          end
        end
        PH_UNK_SYS, PH_UNK_CUST: begin
          nxt = unknown_tok(nxt, tok_end, close_paren);
          hit = close_paren;
        end
        default: begin
          if (ws) begin
            hit = 1'b0;
          end else if (close_paren) begin
            hit = 1'b1;
          end else begin
            nxt = start_token(nxt, byte_i);
          end
        end
      endcase
      if (!hit && last_i) begin
        hit     = 1'b1;
        st_code = end_status(nxt.phase);
      end
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.status = st_code;
    if (st_code == ST_OK) begin
      res_o.deleted      = nxt.flag_bits[0];
      res_o.flagged      = nxt.flag_bits[1];
      res_o.replied      = nxt.flag_bits[2];
      res_o.seen_read    = nxt.flag_bits[3];
      res_o.old_mark     = nxt.flag_bits[FLAG_OLD];
      res_o.system_count = nxt.sys_cnt;
      res_o.custom_count = nxt.cust_cnt;
      res_o.consumed     = nxt.byte_cnt;
    end
  end

  always_comb begin
    state_o = nxt;
    if (state_i.done || hit) begin
      if (last_i) begin
        state_o = PARSE_IDLE;
      end else begin
        state_o.done = 1'b1;
      end
    end
  end

  assign res_valid_o = hit;

endmodule

// ----- src/imap_flags_list_parser.sv -----
// ----------------------------------------------------------------------------
// imap_flags_list_parser
// Byte-serial parser for one IMAP FLAGS response; one summary per response.
// The summary is in the output register in the cycle after the byte that
// completes or breaks the response is accepted. Throughput: one byte per cycle
// while no summary stalls; bounded by the single parse-state register.
// Reset: async active low; parse state idle, output empty, mark_old set to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imap_flags_list_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // mark_old
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,     // [7:0] byte_in
  input  logic        s_axis_tlast,     // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata      // [1:0] status, [2] deleted, [3] flagged,
                                        // [4] replied, [5] seen_read, [6] old_mark,
                                        // [10:7] system_count, [14:11] custom_count,
                                        // [30:15] consumed, [31] zero
);
  import ifp_pkg::*;

  parse_state_t state_q, state_d;
  result_t      res_d, res_q;
  logic         res_hit;
  logic         out_valid_q;
  logic         mark_old_q;
  logic         req_accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign req_accept    = s_axis_tvalid && s_axis_tready;

  ifp_step u_ifp_step (
    .state_i     (state_q),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .mark_old_i  (mark_old_q),
    .state_o     (state_d),
    .res_valid_o (res_hit),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PARSE_IDLE;
      out_valid_q <= 1'b0;
      mark_old_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        mark_old_q <= cfg_wdata_i;
      end
      if (req_accept) begin
        state_q <= state_d;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (req_accept && res_hit) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept && res_hit) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.consumed, res_q.custom_count,
                          res_q.system_count, res_q.old_mark, res_q.seen_read,
                          res_q.replied, res_q.flagged, res_q.deleted,
                          res_q.status};

endmodule

// ----- src/ifp_checker.sv -----
// ----------------------------------------------------------------------------
// ifp_checker
// Port-level checks for the IMAP FLAGS list parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "imap_flags_list_parser_macros.svh"

module ifp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // stalled summary holds
  `IFP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // error summaries carry nothing but the status
  `IFP_ASSERT_IMP(a_err_clean, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0), m_axis_tdata[31:2] == 30'd0)

  // a good list has consumed at least one byte
  `IFP_ASSERT_IMP(a_ok_count, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[1:0] == 2'd0), m_axis_tdata[30:15] != 16'd0)

  // empty output register never blocks input
  `IFP_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // no summary appears without a request
  `IFP_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready), !m_axis_tvalid)

endmodule

bind imap_flags_list_parser ifp_checker u_ifp_checker (.*);
